>>> sv/lzd_pkg.sv
package lzd_pkg;

  localparam int DIST_W = 13;
  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;

  // longest copy taken from one token; longer requests are clipped
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(63);

  // a literal of zero means the token carries no literal
  localparam logic [BYTE_W-1:0] NO_LITERAL = '0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_LIT,
    ST_ERR
  } lzd_state_t;

endpackage

>>> sv/lzd_ram.sv
module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/lz77_token_decoder.sv
// LZ77 triple decoder. Each request on the input channel is one token
// (distance, match_length, literal, new_stream); the block copies the
// clipped match_length bytes from the history window, one byte per cycle
// unless the output stalls, then appends the literal if it is nonzero, and
// flags the final byte of the token with last. A token with a nonzero
// clipped match_length whose distance is zero or reaches past the bytes of
// the current stream yields a single result with bad_distance set and is
// otherwise dropped. The single history RAM takes one read and one write
// per cycle, and each copied byte is read through its registered output.
// The history needs no initialization after reset.
module lz77_token_decoder
  import lzd_pkg::*;
#(
  parameter int WINDOW = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              new_stream,
  input  logic [DIST_W-1:0] distance,
  input  logic [LEN_W-1:0]  match_length,
  input  logic [BYTE_W-1:0] literal,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] data_byte,
  output logic              last,
  output logic              bad_distance
);

  localparam int AW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW + 1);
  localparam int XW = ((CW > DIST_W) ? CW : DIST_W) + 1;

  lzd_state_t        state, state_next;
  logic [AW-1:0]     wp, wp_next;
  logic [CW-1:0]     avail, avail_next;
  logic [AW-1:0]     rd_addr, rd_addr_next;
  logic [LEN_W-1:0]  reads_left, reads_left_next;
  logic [LEN_W-1:0]  bytes_left, bytes_left_next;
  logic              pipe_valid, pipe_valid_next;
  logic              copied, copied_next;
  logic              dist_one, dist_one_next;
  logic [BYTE_W-1:0] tok_lit, tok_lit_next;
  logic              out_valid_next;
  logic [BYTE_W-1:0] data_byte_next;
  logic              last_next, bad_next;

  logic              can_emit;
  logic              push;
  logic [BYTE_W-1:0] push_data;
  logic              rd_en;
  logic [BYTE_W-1:0] rdata;
  logic [BYTE_W-1:0] copy_byte;
  logic [LEN_W-1:0]  len_c;
  logic [CW-1:0]     avail_base;
  logic [XW-1:0]     dist_x, avail_x, wp_x, rd_x;
  logic              tok_bad;

  lzd_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(WINDOW)
  ) u_hist (
    .clk   (clk),
    .we    (push),
    .waddr (wp),
    .wdata (push_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign in_ready = (state == ST_IDLE);
  assign can_emit = !out_valid || out_ready;

  // token decode, used on the accept cycle
  assign len_c      = (match_length > MAX_LEN) ? MAX_LEN : match_length;
  assign avail_base = new_stream ? '0 : avail;
  assign dist_x     = XW'(distance);
  assign avail_x    = XW'(avail_base);
  assign wp_x       = XW'(wp);
  assign tok_bad    = (len_c != '0) && ((distance == '0) || (dist_x > avail_x));
  assign rd_x       = (wp_x >= dist_x) ? (wp_x - dist_x) : (wp_x + XW'(WINDOW) - dist_x);

  // at distance one the RAM read races the write of the previous byte;
  // that byte still sits in the output register, so take it from there
  assign copy_byte = (dist_one && copied) ? data_byte : rdata;

  always_comb begin
    state_next      = state;
    rd_addr_next    = rd_addr;
    reads_left_next = reads_left;
    bytes_left_next = bytes_left;
    pipe_valid_next = pipe_valid;
    copied_next     = copied;
    dist_one_next   = dist_one;
    tok_lit_next    = tok_lit;
    avail_next      = avail;
    out_valid_next  = out_valid && !out_ready;
    data_byte_next  = data_byte;
    last_next       = last;
    bad_next        = bad_distance;
    push            = 1'b0;
    push_data       = copy_byte;
    rd_en           = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          avail_next      = avail_base;
          tok_lit_next    = literal;
          dist_one_next   = (distance == DIST_W'(1));
          rd_addr_next    = rd_x[AW-1:0];
          reads_left_next = len_c;
          bytes_left_next = len_c;
          pipe_valid_next = 1'b0;
          copied_next     = 1'b0;
          if (tok_bad) begin
            state_next = ST_ERR;
          end else if (len_c != '0) begin
            state_next = ST_COPY;
          end else if (literal != NO_LITERAL) begin
            state_next = ST_LIT;
          end
        end
      end
      ST_COPY: begin
        if (pipe_valid && can_emit) begin
          push            = 1'b1;
          push_data       = copy_byte;
          out_valid_next  = 1'b1;
          data_byte_next  = copy_byte;
          last_next       = (bytes_left == LEN_W'(1)) && (tok_lit == NO_LITERAL);
          bad_next        = 1'b0;
          bytes_left_next = bytes_left - LEN_W'(1);
          copied_next     = 1'b1;
          if (bytes_left == LEN_W'(1)) begin
            state_next = (tok_lit == NO_LITERAL) ? ST_IDLE : ST_LIT;
          end
        end
        if ((reads_left != '0) && (!pipe_valid || can_emit)) begin
          rd_en           = 1'b1;
          reads_left_next = reads_left - LEN_W'(1);
          rd_addr_next    = (rd_addr == AW'(WINDOW - 1)) ? '0 : rd_addr + AW'(1);
          pipe_valid_next = 1'b1;
        end else if (pipe_valid && can_emit) begin
          pipe_valid_next = 1'b0;
        end
      end
      ST_LIT: begin
        if (can_emit) begin
          push           = 1'b1;
          push_data      = tok_lit;
          out_valid_next = 1'b1;
          data_byte_next = tok_lit;
          last_next      = 1'b1;
          bad_next       = 1'b0;
          state_next     = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (can_emit) begin
          out_valid_next = 1'b1;
          data_byte_next = '0;
          last_next      = 1'b1;
          bad_next       = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    wp_next = wp;
    if (push) begin
      wp_next = (wp == AW'(WINDOW - 1)) ? '0 : wp + AW'(1);
      if (avail < CW'(WINDOW)) begin
        avail_next = avail + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      wp         <= '0;
      avail      <= '0;
      pipe_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      wp         <= wp_next;
      avail      <= avail_next;
      pipe_valid <= pipe_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr      <= rd_addr_next;
    reads_left   <= reads_left_next;
    bytes_left   <= bytes_left_next;
    copied       <= copied_next;
    dist_one     <= dist_one_next;
    tok_lit      <= tok_lit_next;
    data_byte    <= data_byte_next;
    last         <= last_next;
    bad_distance <= bad_next;
  end

  // outstanding bytes are those not yet read plus the one in flight
  a_copy_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COPY) |-> (bytes_left == reads_left + LEN_W'(pipe_valid)))
    else $error("copy counters out of step");

  a_pipe_in_copy: assert property (@(posedge clk) disable iff (rst)
    pipe_valid |-> (state == ST_COPY))
    else $error("read in flight outside copy");

  a_err_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_distance) |-> (last && (data_byte == '0)))
    else $error("error result malformed");

  a_avail_sat: assert property (@(posedge clk) disable iff (rst)
    (avail <= CW'(WINDOW)) && (XW'(wp) < XW'(WINDOW)))
    else $error("history count or pointer out of range");

  a_push_slot: assert property (@(posedge clk) disable iff (rst)
    push |=> out_valid)
    else $error("history written without a result");

endmodule
